[src/lsrm_pkg.sv]
// ----------------------------------------------------------------------------
// lsrm_pkg
// Shared widths, limits and the controller state type for the level spacing
// ratio mean core.
// ----------------------------------------------------------------------------
`default_nettype none

package lsrm_pkg;

  // Largest window, in levels; ratios stop counting at MAX_LEVELS - 2
  localparam int MAX_LEVELS = 65538;
  // Fraction bits of one ratio
  localparam int RATIO_BITS = 16;

  localparam int LEVEL_W   = 32;              // Q16.16 level
  localparam int SPACE_W   = LEVEL_W;         // clamped spacing, never negative
  localparam int QUO_W     = RATIO_BITS + 1;  // ratio and mean both lie in [0, 1]
  localparam int COUNT_W   = 17;
  localparam int SUM_W     = 33;
  localparam int MEAN_W    = 17;
  localparam int STEP_W    = $clog2(QUO_W);
  localparam int MHI_W     = SUM_W - QUO_W;   // mean dividend bits above the quotient

  localparam logic [COUNT_W-1:0] RATIO_CAP = COUNT_W'(MAX_LEVELS - 2);
  localparam logic [QUO_W-1:0]   RATIO_ONE = QUO_W'(1) << RATIO_BITS;
  localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(QUO_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a level
    S_RDIV,   // ratio division, one quotient bit per cycle
    S_RACC,   // add ratio to the running sum
    S_MPREP,  // form rounded mean dividend
    S_MDIV,   // mean division
    S_EMIT    // hand result to the output register
  } lsrm_state_t;

endpackage

`default_nettype wire

[src/lsrm_if.sv]
// ----------------------------------------------------------------------------
// lsrm_if
// Valid/ready channels of the level spacing ratio mean core: one for incoming
// levels, one for window results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsrm_sample_if;
  import lsrm_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               last_sample;

  modport source (output valid, level, last_sample, input ready);
  modport sink   (input valid, level, last_sample, output ready);
endinterface

interface lsrm_stat_if;
  import lsrm_pkg::*;
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_ratio;
  logic [COUNT_W-1:0] ratio_count;
  logic               degenerate_seen;
  logic               order_error;

  modport source (output valid, mean_ratio, ratio_count, degenerate_seen, order_error,
                  input ready);
  modport sink   (input valid, mean_ratio, ratio_count, degenerate_seen, order_error,
                  output ready);
endinterface

`default_nettype wire

[src/level_spacing_ratio_mean_core.sv]
// ----------------------------------------------------------------------------
// level_spacing_ratio_mean_core
// Mean adjacent-gap ratio of a window of ascending Q16.16 energy levels.
// ----------------------------------------------------------------------------
// Takes one level per request. The first two levels of a window prime the
// history; each later level, while the count is below RATIO_CAP, yields
// min/max of the two adjacent spacings as a 17-bit fraction, added to a
// running sum and counted (if both spacings are zero it is only counted
// and flags degenerate). A level marked last_sample closes the window and
// returns the rounded mean, the count and the degenerate and order flags,
// then the window restarts. A ratio runs 17 divider steps before it is
// accumulated; the mean division, skipped when the count is zero, runs
// before the result is offered. Both divisions share one bit-serial
// restoring divider that produces one quotient bit per cycle; it sets the
// rate. A result waiting in the output register does not stop the next
// level from being taken; it stalls only the next window's close.
// ----------------------------------------------------------------------------
`default_nettype none

module level_spacing_ratio_mean_core (
  input  wire logic   clk,
  input  wire logic   rst,
  lsrm_sample_if.sink samples,
  lsrm_stat_if.source stats
);
  import lsrm_pkg::*;

  lsrm_state_t state, state_next;

  // window state
  logic [LEVEL_W-1:0] prev_level;
  logic [SPACE_W-1:0] prev_spacing;
  logic [1:0]         levels_seen;
  logic [SUM_W-1:0]   ratio_sum;
  logic [COUNT_W-1:0] ratios_taken;
  logic               degenerate_flag;
  logic               order_flag;
  logic               last_hold;

  // shared divider
  logic [SPACE_W-1:0] rem;
  logic [QUO_W-1:0]   dlo;
  logic [SPACE_W-1:0] dvs;
  logic [QUO_W-1:0]   quo;
  logic [STEP_W-1:0]  step;

  // output register
  logic               ovalid;
  logic [MEAN_W-1:0]  omean;
  logic [COUNT_W-1:0] ocount;
  logic               odeg;
  logic               oord;

  logic               accept;
  logic [LEVEL_W:0]   diff;
  logic [SPACE_W-1:0] sp;
  logic               sp_lt;
  logic [SPACE_W-1:0] lo;
  logic [SPACE_W-1:0] hi;
  logic               take;
  logic               hi_zero;
  logic               load_ratio;
  logic               load_mean;
  logic               dividing;
  logic [SPACE_W:0]   trial;
  logic [SPACE_W:0]   trial_sub;
  logic               qbit;
  logic [SUM_W-1:0]   mean_dvd;
  logic               emit_go;

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;

  // New spacing, clamped at zero when levels step down
  assign diff  = {samples.level[LEVEL_W-1], samples.level} - {prev_level[LEVEL_W-1], prev_level};
  assign sp    = diff[LEVEL_W] ? '0 : diff[SPACE_W-1:0];
  assign sp_lt = sp < prev_spacing;
  assign lo    = sp_lt ? sp : prev_spacing;
  assign hi    = sp_lt ? prev_spacing : sp;
  assign hi_zero = (hi == '0);
  assign take  = (levels_seen == 2'd2) && (ratios_taken < RATIO_CAP);

  assign load_ratio = accept && take && !hi_zero;
  assign load_mean  = (state == S_MPREP) && (ratios_taken != '0);
  assign dividing   = (state == S_RDIV) || (state == S_MDIV);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem, dlo[QUO_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign qbit      = !trial_sub[SPACE_W];

  // Mean rounded half up: (sum + count/2) / count
  assign mean_dvd = ratio_sum + SUM_W'(ratios_taken >> 1);

  assign emit_go = (state == S_EMIT) && (!ovalid || stats.ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (take && !hi_zero)          state_next = S_RDIV;
          else if (samples.last_sample)  state_next = S_MPREP;
        end
      end
      S_RDIV:  if (step == LAST_STEP) state_next = S_RACC;
      S_RACC:  state_next = last_hold ? S_MPREP : S_IDLE;
      S_MPREP: state_next = (ratios_taken == '0) ? S_EMIT : S_MDIV;
      S_MDIV:  if (step == LAST_STEP) state_next = S_EMIT;
      S_EMIT:  if (emit_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Controller and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      prev_level      <= '0;
      prev_spacing    <= '0;
      levels_seen     <= '0;
      ratio_sum       <= '0;
      ratios_taken    <= '0;
      degenerate_flag <= 1'b0;
      order_flag      <= 1'b0;
      last_hold       <= 1'b0;
      step            <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        prev_level <= samples.level;
        last_hold  <= samples.last_sample;
        if (levels_seen != 2'd2) levels_seen <= levels_seen + 2'd1;
        if (levels_seen != 2'd0) begin
          prev_spacing <= sp;
          if (diff[LEVEL_W]) order_flag <= 1'b1;
        end
        if (take) begin
          ratios_taken <= ratios_taken + COUNT_W'(1);
          if (hi_zero) degenerate_flag <= 1'b1;
        end
      end
      if (load_ratio || load_mean) step <= '0;
      else if (dividing)           step <= step + STEP_W'(1);
      if (state == S_RACC) ratio_sum <= ratio_sum + SUM_W'(quo);
      // window restarts once the result is handed over
      if (emit_go) begin
        prev_level      <= '0;
        prev_spacing    <= '0;
        levels_seen     <= '0;
        ratio_sum       <= '0;
        ratios_taken    <= '0;
        degenerate_flag <= 1'b0;
        order_flag      <= 1'b0;
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (load_ratio) begin
      // dividend is lo << RATIO_BITS; its bits above the quotient are lo >> 1
      rem <= lo >> 1;
      dlo <= {lo[0], RATIO_BITS'(0)};
      dvs <= hi;
    end else if (load_mean) begin
      rem <= SPACE_W'(mean_dvd[SUM_W-1 -: MHI_W]);
      dlo <= mean_dvd[QUO_W-1:0];
      dvs <= SPACE_W'(ratios_taken);
    end else if (dividing) begin
      rem <= qbit ? trial_sub[SPACE_W-1:0] : trial[SPACE_W-1:0];
      dlo <= dlo << 1;
      quo <= {quo[QUO_W-2:0], qbit};
    end
    if ((state == S_MPREP) && (ratios_taken == '0)) quo <= '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit_go) begin
      ovalid <= 1'b1;
    end else if (stats.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      omean  <= quo;
      ocount <= ratios_taken;
      odeg   <= degenerate_flag;
      oord   <= order_flag;
    end
  end

  assign stats.valid           = ovalid;
  assign stats.mean_ratio      = omean;
  assign stats.ratio_count     = ocount;
  assign stats.degenerate_seen = odeg;
  assign stats.order_error     = oord;

  // Partial remainder stays below the divisor through every step
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RDIV) || (state == S_MDIV)) |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  // A finished ratio never exceeds one
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RACC) |-> (quo <= RATIO_ONE))
    else $error("ratio above one");

  // Count never passes the cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    ratios_taken <= RATIO_CAP)
    else $error("ratio count above cap");

  // Handing over a result empties the window
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> ((levels_seen == 2'd0) && (ratios_taken == '0) && ovalid))
    else $error("window not cleared after result");

endmodule

`default_nettype wire
